// File: design/alc_pkg.sv
// Shared types and constants for the array list with cursor.
package alc_pkg;

	localparam int unsigned CapacityDef = 64;
	localparam int unsigned WordW = 32;
	localparam int unsigned CountW = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIRST  = 2'd1,
		OP_NEXT   = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_END   = 2'd2,
		ST_NOCUR = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CH_HOLD   = 2'd0,
		CH_PUSH   = 2'd1,
		CH_POP    = 2'd2,
		CH_APPEND = 2'd3
	} chain_op_t;

	typedef struct packed {
		chain_op_t        op;
		logic [WordW-1:0] word;
	} chain_ctl_t;

endpackage

// File: design/alc_cell.sv
// One storage cell of a word chain: holds a word, or takes it from a neighbor or the load bus.
module alc_cell (
	input  logic                          clk,
	input  alc_pkg::chain_ctl_t           ctl,
	input  logic                          hit,
	input  logic [alc_pkg::WordW-1:0]     from_lo,
	input  logic [alc_pkg::WordW-1:0]     from_hi,
	output logic [alc_pkg::WordW-1:0]     word
);

	logic [alc_pkg::WordW-1:0] word_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			alc_pkg::CH_PUSH: begin
				word_q <= from_lo;
			end
			alc_pkg::CH_POP: begin
				word_q <= from_hi;
			end
			alc_pkg::CH_APPEND: begin
				if (hit) begin
					word_q <= ctl.word;
				end
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

	assign word = word_q;

endmodule

// File: design/alc_chain.sv
// A row of cells forming a stack with its top at cell 0 and an indexed append.
module alc_chain #(
	parameter int unsigned CAPACITY = alc_pkg::CapacityDef,
	parameter int unsigned IDX_W    = $clog2(CAPACITY)
) (
	input  logic                      clk,
	input  alc_pkg::chain_ctl_t       ctl,
	input  logic [IDX_W-1:0]          idx,
	output logic [alc_pkg::WordW-1:0] head
);

	logic [alc_pkg::WordW-1:0] cell_word [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [alc_pkg::WordW-1:0] lo_word;
		logic [alc_pkg::WordW-1:0] hi_word;
		logic                      hit;

		if (i == 0) begin : g_first
			assign lo_word = ctl.word;
		end else begin : g_mid_lo
			assign lo_word = cell_word[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign hi_word = cell_word[i];
		end else begin : g_mid_hi
			assign hi_word = cell_word[i+1];
		end

		assign hit = (idx == IDX_W'(i));

		alc_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.hit     (hit),
			.from_lo (lo_word),
			.from_hi (hi_word),
			.word    (cell_word[i])
		);
	end

	assign head = cell_word[0];

endmodule

// File: design/array_list_with_cursor_unit.sv
// Top level of the array list with cursor: controller, two cell chains and result register.
//
// The list is kept as two chains of cells split at the cursor: the left chain holds the
// entries up to and including the current one, newest on top, and the right chain holds
// the entries after it, the next one at its head. Insert, next and remove write their result
// into the result register as the beat is accepted, and a new beat is taken in the cycle the
// result is taken. First with a current entry first moves the left chain back onto the right
// chain one word per cycle in an unwind state, then emits once the result register is free;
// with no current entry it needs no unwind. No clearing pass runs after reset.
module array_list_with_cursor_unit #(
	parameter int unsigned CAPACITY = alc_pkg::CapacityDef
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        op,
	input  logic signed [alc_pkg::WordW-1:0]  data_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic signed [alc_pkg::WordW-1:0]  data_out,
	output logic [alc_pkg::CountW-1:0]        count
);

	localparam int unsigned IDX_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic {
		S_IDLE,
		S_UNWIND
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            lcount_q;
	logic [CNT_W-1:0]            rcount_q;
	logic [CNT_W-1:0]            fill_q;
	logic                        out_valid_q;
	alc_pkg::status_t            status_q;
	logic [alc_pkg::WordW-1:0]   data_q;
	logic [alc_pkg::CountW-1:0]  count_q;

	alc_pkg::chain_ctl_t         l_ctl;
	alc_pkg::chain_ctl_t         r_ctl;
	logic [alc_pkg::WordW-1:0]   lhead;
	logic [alc_pkg::WordW-1:0]   rhead;

	alc_pkg::op_t                op_in;
	logic                        accept;
	logic                        do_ins;
	logic                        do_next;
	logic                        do_rem;
	logic                        do_move;
	logic                        go_unwind;
	logic                        fin_unwind;
	logic                        emit;
	alc_pkg::status_t            res_status;
	logic [alc_pkg::WordW-1:0]   res_data;
	logic [CNT_W-1:0]            fill_next;
	logic [CNT_W-1:0]            lcount_next;
	logic [CNT_W-1:0]            rcount_next;
	logic [CNT_W+alc_pkg::CountW-1:0] fill_ext;

	assign op_in    = alc_pkg::op_t'(op);
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	always_comb begin
		fin_unwind = (state_q == S_UNWIND) && (lcount_q == '0) && !out_valid_q;
		do_move    = (state_q == S_UNWIND) && (lcount_q != '0);
		do_ins     = accept && (op_in == alc_pkg::OP_INSERT) && (fill_q < CNT_W'(CAPACITY));
		do_rem     = accept && (op_in == alc_pkg::OP_REMOVE) && (lcount_q != '0);
		go_unwind  = accept && (op_in == alc_pkg::OP_FIRST) && (fill_q != '0) &&
			(lcount_q != '0);
		do_next    = (accept && (op_in == alc_pkg::OP_NEXT) && (rcount_q != '0)) ||
			(accept && (op_in == alc_pkg::OP_FIRST) && (fill_q != '0) &&
			(lcount_q == '0)) || fin_unwind;
		emit       = (accept && !go_unwind) || fin_unwind;

		r_ctl = '{op: alc_pkg::CH_HOLD, word: data_in};
		if (do_ins) begin
			r_ctl = '{op: alc_pkg::CH_APPEND, word: data_in};
		end else if (do_next) begin
			r_ctl = '{op: alc_pkg::CH_POP, word: data_in};
		end else if (do_move) begin
			r_ctl = '{op: alc_pkg::CH_PUSH, word: lhead};
		end

		l_ctl = '{op: alc_pkg::CH_HOLD, word: rhead};
		if (do_next) begin
			l_ctl = '{op: alc_pkg::CH_PUSH, word: rhead};
		end else if (do_rem || do_move) begin
			l_ctl = '{op: alc_pkg::CH_POP, word: rhead};
		end

		res_status = alc_pkg::ST_OK;
		res_data   = '0;
		if (state_q == S_UNWIND) begin
			res_data = rhead;
		end else begin
			case (op_in)
				alc_pkg::OP_INSERT: begin
					if (!do_ins) begin
						res_status = alc_pkg::ST_FULL;
					end
				end
				alc_pkg::OP_FIRST: begin
					if (fill_q == '0) begin
						res_status = alc_pkg::ST_END;
					end else begin
						res_data = rhead;
					end
				end
				alc_pkg::OP_NEXT: begin
					if (rcount_q == '0) begin
						res_status = alc_pkg::ST_END;
					end else begin
						res_data = rhead;
					end
				end
				alc_pkg::OP_REMOVE: begin
					if (lcount_q == '0) begin
						res_status = alc_pkg::ST_NOCUR;
					end else begin
						res_data = lhead;
					end
				end
				default: begin
					res_status = alc_pkg::ST_OK;
				end
			endcase
		end

		fill_next   = fill_q + CNT_W'(do_ins) - CNT_W'(do_rem);
		lcount_next = lcount_q + CNT_W'(do_next) - CNT_W'(do_rem) - CNT_W'(do_move);
		rcount_next = rcount_q + CNT_W'(do_ins) - CNT_W'(do_next) + CNT_W'(do_move);
		fill_ext    = {alc_pkg::CountW'(0), fill_next};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lcount_q    <= '0;
			rcount_q    <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= alc_pkg::ST_OK;
			data_q      <= '0;
			count_q     <= '0;
		end else begin
			lcount_q <= lcount_next;
			rcount_q <= rcount_next;
			fill_q   <= fill_next;
			case (state_q)
				S_IDLE: begin
					if (go_unwind) begin
						state_q <= S_UNWIND;
					end
				end
				S_UNWIND: begin
					if (fin_unwind) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
				status_q    <= res_status;
				data_q      <= res_data;
				count_q     <= fill_ext[alc_pkg::CountW-1:0];
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	alc_chain #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W)
	) u_left (
		.clk  (clk),
		.ctl  (l_ctl),
		.idx  (IDX_W'(0)),
		.head (lhead)
	);

	alc_chain #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W)
	) u_right (
		.clk  (clk),
		.ctl  (r_ctl),
		.idx  (rcount_q[IDX_W-1:0]),
		.head (rhead)
	);

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_out  = $signed(data_q);
	assign count     = count_q;

`ifndef NO_ASSERTIONS
	a_split_sum: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == lcount_q + rcount_q)
		else $error("Chain counts do not add up to the fill count.");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("Fill count exceeds capacity.");

	a_unwind_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UNWIND) |-> !out_valid_q)
		else $error("Result register busy while first is unwinding.");

	a_unwind_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_UNWIND) && (lcount_q != '0)) |=>
		(lcount_q == $past(lcount_q) - CNT_W'(1)) && (fill_q == $past(fill_q)))
		else $error("Unwind step did not move exactly one word.");
`endif

endmodule

// File: dv/alc_result_checker.sv
// Checker that predicts each result of the array list with cursor and compares it with the block.
module alc_result_checker
	import alc_pkg::*;
#(
	parameter int unsigned CAPACITY = CapacityDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        op,
	input  logic [WordW-1:0]  data_in,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [1:0]        status,
	input  logic [WordW-1:0]  data_out,
	input  logic [CountW-1:0] count,
	output int unsigned       fail_count,
	output int unsigned       pending,
	output int unsigned       checked,
	output int unsigned       full_hits
);

	typedef struct packed {
		status_t           st;
		logic [WordW-1:0]  word;
		logic [CountW-1:0] cnt;
	} list_result_t;

	logic [WordW-1:0] shadow [CAPACITY];
	int               fill;
	int               cursor_pos;
	int unsigned      errs;
	int unsigned      seen;
	int unsigned      refused;
	list_result_t     awaited [$];
	list_result_t     head;

	function automatic list_result_t apply_op(op_t kind, logic [WordW-1:0] word);
		list_result_t r;
		int           i;
		r.st = ST_OK;
		r.word = '0;
		case (kind)
			OP_INSERT: begin
				if (fill >= int'(CAPACITY)) begin
					r.st = ST_FULL;
				end else begin
					shadow[fill] = word;
					fill++;
				end
			end
			OP_FIRST: begin
				if (fill == 0) begin
					r.st = ST_END;
				end else begin
					cursor_pos = 0;
					r.word = shadow[0];
				end
			end
			OP_NEXT: begin
				if (cursor_pos >= fill - 1 || cursor_pos + 1 >= int'(CAPACITY)) begin
					r.st = ST_END;
				end else begin
					cursor_pos++;
					r.word = shadow[cursor_pos];
				end
			end
			default: begin
				if (cursor_pos < 0 || cursor_pos >= fill) begin
					r.st = ST_NOCUR;
				end else begin
					r.word = shadow[cursor_pos];
					for (i = cursor_pos; i < fill - 1; i++)
						shadow[i] = shadow[i + 1];
					cursor_pos--;
					fill--;
				end
			end
		endcase
		r.cnt = fill[CountW-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			cursor_pos = -1;
			errs = 0;
			seen = 0;
			refused = 0;
			awaited.delete();
		end else begin
			if (out_valid && out_ready) begin
				seen++;
				if (awaited.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("Result beat %0d arrived with nothing pending: status %0d data %h count %0d",
							seen, status, data_out, count);
				end else begin
					head = awaited.pop_front();
					if (status != head.st || data_out != head.word || count != head.cnt) begin
						errs++;
						if (errs <= 10)
							$display("Mismatch on result %0d: status %0d/%0d data %h/%h count %0d/%0d (expected/actual)",
								seen, head.st, status, head.word, data_out, head.cnt, count);
					end
				end
			end
			if (in_valid && in_ready) begin
				head = apply_op(op_t'(op), data_in);
				if (head.st == ST_FULL)
					refused++;
				awaited.push_back(head);
			end
		end
		fail_count <= errs;
		pending <= awaited.size();
		checked <= seen;
		full_hits <= refused;
	end

endmodule

// File: dv/tb_top.sv
// Testbench top for the array list with cursor: clock, reset, stimulus, pacing and verdict.
module tb_top;
	import alc_pkg::*;

	localparam int unsigned Capacity = CapacityDef;
	localparam int unsigned RandomBeats = 1300;
	localparam int unsigned QuietBeats = 200;
	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned DrainCycles = Capacity + 16;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              op = OP_INSERT;
	logic signed [WordW-1:0] data_in = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [1:0]              status;
	logic signed [WordW-1:0] data_out;
	logic [CountW-1:0]       count;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned checked;
	int unsigned full_hits;
	int unsigned cycles;
	int unsigned op_tally [4] = '{0, 0, 0, 0};
	bit          quiet = 1'b0;

	array_list_with_cursor_unit #(
		.CAPACITY(Capacity)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.data_in  (data_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.data_out (data_out),
		.count    (count)
	);

	alc_result_checker #(
		.CAPACITY(Capacity)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.data_out  (data_out),
		.count     (count),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked),
		.full_hits (full_hits)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : result_pacing
		int unsigned span;
		@(posedge arst_n);
		forever begin
			if (quiet || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
				span = $urandom_range(1, 12);
			end else begin
				out_ready <= 1'b0;
				span = $urandom_range(1, 4);
			end
			repeat (span) @(posedge clk);
		end
	end

	task automatic send_beat(input op_t kind, input logic [WordW-1:0] word);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		op <= kind;
		data_in <= word;
		in_valid <= 1'b1;
		op_tally[int'(kind)]++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned n;
		int unsigned mix;
		int unsigned pick;
		op_t         kind;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list cases, then extreme words, a walk, removes in the middle, at entry 0 and at the end.
		send_beat(OP_FIRST, 32'h0000_0000);
		send_beat(OP_NEXT, 32'hFFFF_FFFF);
		send_beat(OP_REMOVE, 32'h1234_5678);
		send_beat(OP_INSERT, 32'h8000_0000);
		send_beat(OP_INSERT, 32'h7FFF_FFFF);
		send_beat(OP_INSERT, 32'h0000_0000);
		send_beat(OP_INSERT, 32'hFFFF_FFFF);
		send_beat(OP_INSERT, 32'h5555_5555);
		send_beat(OP_INSERT, 32'hAAAA_AAAA);
		send_beat(OP_NEXT, 32'h0);
		send_beat(OP_NEXT, 32'h0);
		send_beat(OP_REMOVE, 32'h0);
		send_beat(OP_NEXT, 32'h0);
		send_beat(OP_FIRST, 32'h0);
		send_beat(OP_REMOVE, 32'h0);
		send_beat(OP_REMOVE, 32'h0);
		send_beat(OP_NEXT, 32'h0);
		send_beat(OP_NEXT, 32'h0);
		send_beat(OP_NEXT, 32'h0);
		send_beat(OP_NEXT, 32'h0);
		send_beat(OP_REMOVE, 32'h0);
		send_beat(OP_NEXT, 32'h0);
		send_beat(OP_NEXT, 32'h0);
		send_beat(OP_FIRST, 32'h0);
		wait_for_results();

		// Segments alternate between filling, walking, draining and an even mix of operations.
		for (n = 0; n < RandomBeats; n++) begin
			quiet = (n >= RandomBeats - QuietBeats);
			mix = (n / 100) % 4;
			pick = $urandom_range(0, 99);
			case (mix)
				0: kind = pick < 75 ? OP_INSERT : pick < 80 ? OP_FIRST :
					pick < 92 ? OP_NEXT : OP_REMOVE;
				1: kind = pick < 20 ? OP_INSERT : pick < 35 ? OP_FIRST :
					pick < 80 ? OP_NEXT : OP_REMOVE;
				2: kind = pick < 10 ? OP_INSERT : pick < 40 ? OP_FIRST :
					pick < 60 ? OP_NEXT : OP_REMOVE;
				default: kind = op_t'(pick % 4);
			endcase
			send_beat(kind, $urandom());
			if (n == RandomBeats / 2)
				wait_for_results();
		end

		wait_for_results();
		repeat (DrainCycles) @(posedge clk);

		$display("Drove %0d beats: %0d insert, %0d first, %0d next, %0d remove.",
			op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
			op_tally[0], op_tally[1], op_tally[2], op_tally[3]);
		$display("Checked %0d results; %0d inserts were refused on a full list.",
			checked, full_hits);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/alc_pkg.sv
design/alc_cell.sv
design/alc_chain.sv
design/array_list_with_cursor_unit.sv
dv/alc_result_checker.sv
dv/tb_top.sv
